// ----- src/trqa_pkg.sv -----
// Package for the two-class request admission queue.
// Holds command, result status, per-id state and sequencer state codes.
// No dependencies.
package trqa_pkg;

    typedef enum logic [1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RES_OK        = 3'd0,
        RES_QUEUED    = 3'd1,
        RES_IN_FLIGHT = 3'd2,
        RES_FULL      = 3'd3,
        RES_NOT_FOUND = 3'd4
    } res_t;

    typedef enum logic [1:0] {
        ID_IDLE    = 2'd0,
        ID_PENDING = 2'd1,
        ID_ACTIVE  = 2'd2,
        ID_SPARE   = 2'd3
    } id_state_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_READY,
        S_STAT,
        S_APP,
        S_POP,
        S_RM1,
        S_RMP,
        S_RMN,
        S_EMIT
    } fsm_t;

    localparam logic [8:0] MAX_ACTIVE_RESET = 9'd20;

endpackage

// ----- src/trqa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module trqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/two_class_request_admission_queue.sv -----
// Two-class request admission queue: sequencer over a status RAM and a link RAM.
// Depends on trqa_pkg and trqa_ram.
//
// Usage: one item on the input channel (command, request_id, low_priority) gives
// one result item on the output channel (status, start_valid, start_id,
// active_total, pending_total). Handshake is valid/stall on both sides.
// Queued requests are kept as two doubly linked lists, regular and low, held in
// a link RAM indexed by request id; a status RAM holds each id's state.
// From acceptance to result, a plain item passes S_STAT and S_EMIT; a submit
// appended behind a tail passes S_STAT, S_APP, S_EMIT; a pop of the queue head
// passes S_STAT, S_POP, S_EMIT; a cancel that removes an entry from the middle of
// a list passes S_STAT, S_RM1, S_RMP, S_RMN, S_EMIT. Each step is one RAM read and
// write-back. One item is in work at a time: the next is accepted in the cycle after
// the last result is registered. After reset a clearing pass writes every status
// RAM entry to idle, during which in_stall is high; max_active resets to 20.
// When the receiver stalls, the result is held; the block accepts one more item
// and holds that item's result until the first one has been taken.
module two_class_request_admission_queue #(
    parameter int ID_COUNT    = 256,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  request_id,
    input  logic        low_priority,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        start_valid,
    output logic [7:0]  start_id,
    output logic [8:0]  active_total,
    output logic [6:0]  pending_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDW = $clog2(ID_COUNT);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int LW  = 1 + 2 * IDW;

    trqa_pkg::fsm_t state_reg, state_next;

    logic [1:0]     cmd_reg, cmd_next;
    logic [IDW-1:0] id_reg, id_next;
    logic           idok_reg, idok_next;
    logic           low_reg, low_next;
    logic [IDW-1:0] x_reg, x_next;
    logic [IDW-1:0] n_reg, n_next;
    logic [IDW-1:0] p_reg, p_next;
    logic [IDW-1:0] clr_reg, clr_next;
    logic [IDW-1:0] head_reg [2];
    logic [IDW-1:0] head_next [2];
    logic [IDW-1:0] tail_reg [2];
    logic [IDW-1:0] tail_next [2];
    logic [CW-1:0]  cnt_reg [2];
    logic [CW-1:0]  cnt_next [2];
    logic [8:0]     act_reg, act_next;
    logic [8:0]     max_reg;
    logic [2:0]     res_reg, res_next;
    logic           sv_reg, sv_next;
    logic [IDW-1:0] sid_reg, sid_next;

    logic           out_valid_reg, out_valid_next;
    logic [2:0]     out_status_reg, out_status_next;
    logic           out_sv_reg, out_sv_next;
    logic [7:0]     out_sid_reg, out_sid_next;
    logic [8:0]     out_act_reg, out_act_next;
    logic [6:0]     out_pend_reg, out_pend_next;

    logic           st_we;
    logic [IDW-1:0] st_waddr, st_raddr;
    logic [1:0]     st_wdata, st_rdata;
    logic           ln_we;
    logic [IDW-1:0] ln_waddr, ln_raddr;
    logic [LW-1:0]  ln_wdata, ln_rdata;

    logic           d_cls;
    logic [IDW-1:0] d_nxt, d_prv;
    logic [CW:0]    pend_sum;
    logic           hd_cls;
    logic           in_accept;

    trqa_ram #(.WIDTH(2), .DEPTH(ID_COUNT)) u_stat_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    trqa_ram #(.WIDTH(LW), .DEPTH(ID_COUNT)) u_link_ram (
        .clk     (clk),
        .wr_en   (ln_we),
        .wr_addr (ln_waddr),
        .wr_data (ln_wdata),
        .rd_addr (ln_raddr),
        .rd_data (ln_rdata)
    );

    assign d_cls    = ln_rdata[LW-1];
    assign d_nxt    = ln_rdata[2*IDW-1:IDW];
    assign d_prv    = ln_rdata[IDW-1:0];
    assign pend_sum = (CW+1)'(cnt_reg[0]) + (CW+1)'(cnt_reg[1]);
    assign hd_cls   = (cnt_reg[0] == '0);
    assign in_accept = in_valid && !in_stall;

    assign in_stall = (state_reg != trqa_pkg::S_READY);
    assign pready   = 1'b1;
    assign prdata   = {23'd0, max_reg};

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign start_valid   = out_sv_reg;
    assign start_id      = out_sid_reg;
    assign active_total  = out_act_reg;
    assign pending_total = out_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trqa_pkg::S_CLEAR;
            clr_reg       <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            act_reg       <= '0;
            max_reg       <= trqa_pkg::MAX_ACTIVE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg[0]    <= cnt_next[0];
            cnt_reg[1]    <= cnt_next[1];
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite)
            begin
                max_reg <= pwdata[8:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        idok_reg       <= idok_next;
        low_reg        <= low_next;
        x_reg          <= x_next;
        n_reg          <= n_next;
        p_reg          <= p_next;
        head_reg[0]    <= head_next[0];
        head_reg[1]    <= head_next[1];
        tail_reg[0]    <= tail_next[0];
        tail_reg[1]    <= tail_next[1];
        res_reg        <= res_next;
        sv_reg         <= sv_next;
        sid_reg        <= sid_next;
        out_status_reg <= out_status_next;
        out_sv_reg     <= out_sv_next;
        out_sid_reg    <= out_sid_next;
        out_act_reg    <= out_act_next;
        out_pend_reg   <= out_pend_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        idok_next       = idok_reg;
        low_next        = low_reg;
        x_next          = x_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        clr_next        = clr_reg;
        head_next[0]    = head_reg[0];
        head_next[1]    = head_reg[1];
        tail_next[0]    = tail_reg[0];
        tail_next[1]    = tail_reg[1];
        cnt_next[0]     = cnt_reg[0];
        cnt_next[1]     = cnt_reg[1];
        act_next        = act_reg;
        res_next        = res_reg;
        sv_next         = sv_reg;
        sid_next        = sid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_sv_next     = out_sv_reg;
        out_sid_next    = out_sid_reg;
        out_act_next    = out_act_reg;
        out_pend_next   = out_pend_reg;
        st_we           = 1'b0;
        st_waddr        = id_reg;
        st_wdata        = trqa_pkg::ID_IDLE;
        st_raddr        = IDW'(request_id);
        ln_we           = 1'b0;
        ln_waddr        = x_reg;
        ln_wdata        = ln_rdata;
        ln_raddr        = x_reg;

        unique case (state_reg)
            trqa_pkg::S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = trqa_pkg::ID_IDLE;
                clr_next = clr_reg + IDW'(1);
                if (32'(clr_reg) == ID_COUNT - 1)
                begin
                    state_next = trqa_pkg::S_READY;
                end
            end
            trqa_pkg::S_READY:
            begin
                if (in_accept)
                begin
                    cmd_next   = command;
                    id_next    = IDW'(request_id);
                    idok_next  = (32'(request_id) < ID_COUNT);
                    low_next   = low_priority;
                    sv_next    = 1'b0;
                    sid_next   = '0;
                    state_next = trqa_pkg::S_STAT;
                end
            end
            trqa_pkg::S_STAT:
            begin
                res_next   = trqa_pkg::RES_NOT_FOUND;
                state_next = trqa_pkg::S_EMIT;
                if (idok_reg)
                begin
                    priority if (cmd_reg == trqa_pkg::CMD_SUBMIT)
                    begin
                        priority if (st_rdata != trqa_pkg::ID_IDLE)
                        begin
                            res_next = trqa_pkg::RES_IN_FLIGHT;
                        end
                        else if (act_reg < max_reg)
                        begin
                            st_we    = 1'b1;
                            st_wdata = trqa_pkg::ID_ACTIVE;
                            act_next = act_reg + 9'd1;
                            res_next = trqa_pkg::RES_OK;
                            sv_next  = 1'b1;
                            sid_next = id_reg;
                        end
                        else if (32'(pend_sum) >= QUEUE_DEPTH)
                        begin
                            res_next = trqa_pkg::RES_FULL;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_wdata = trqa_pkg::ID_PENDING;
                            res_next = trqa_pkg::RES_QUEUED;
                            ln_we    = 1'b1;
                            ln_waddr = id_reg;
                            ln_wdata = {low_reg, {IDW{1'b0}}, tail_reg[low_reg]};
                            ln_raddr = tail_reg[low_reg];
                            x_next   = id_reg;
                            if (cnt_reg[low_reg] == '0)
                            begin
                                head_next[low_reg] = id_reg;
                                tail_next[low_reg] = id_reg;
                                cnt_next[low_reg]  = cnt_reg[low_reg] + CW'(1);
                            end
                            else
                            begin
                                state_next = trqa_pkg::S_APP;
                            end
                        end
                    end
                    else if ((cmd_reg == trqa_pkg::CMD_COMPLETE ||
                              cmd_reg == trqa_pkg::CMD_CANCEL) &&
                             st_rdata == trqa_pkg::ID_ACTIVE)
                    begin
                        st_we    = 1'b1;
                        st_wdata = trqa_pkg::ID_IDLE;
                        res_next = trqa_pkg::RES_OK;
                        if (pend_sum == '0)
                        begin
                            act_next = act_reg - ((act_reg != '0) ? 9'd1 : 9'd0);
                        end
                        else
                        begin
                            act_next   = act_reg - ((act_reg != '0) ? 9'd1 : 9'd0) + 9'd1;
                            x_next     = head_reg[hd_cls];
                            ln_raddr   = head_reg[hd_cls];
                            sv_next    = 1'b1;
                            sid_next   = head_reg[hd_cls];
                            state_next = trqa_pkg::S_POP;
                        end
                    end
                    else if (cmd_reg == trqa_pkg::CMD_CANCEL &&
                             st_rdata == trqa_pkg::ID_PENDING)
                    begin
                        st_we      = 1'b1;
                        st_wdata   = trqa_pkg::ID_IDLE;
                        res_next   = trqa_pkg::RES_OK;
                        x_next     = id_reg;
                        ln_raddr   = id_reg;
                        state_next = trqa_pkg::S_RM1;
                    end
                    else
                    begin
                        res_next = trqa_pkg::RES_NOT_FOUND;
                    end
                end
            end
            trqa_pkg::S_APP:
            begin
                ln_we             = 1'b1;
                ln_waddr          = tail_reg[low_reg];
                ln_wdata          = {d_cls, x_reg, d_prv};
                tail_next[low_reg] = x_reg;
                cnt_next[low_reg] = cnt_reg[low_reg] + CW'(1);
                state_next        = trqa_pkg::S_EMIT;
            end
            trqa_pkg::S_POP,
            trqa_pkg::S_RM1:
            begin
                if (state_reg == trqa_pkg::S_POP)
                begin
                    st_we    = 1'b1;
                    st_waddr = x_reg;
                    st_wdata = trqa_pkg::ID_ACTIVE;
                end
                cnt_next[d_cls] = cnt_reg[d_cls] - CW'(1);
                state_next      = trqa_pkg::S_EMIT;
                priority if (cnt_reg[d_cls] == CW'(1))
                begin
                    state_next = trqa_pkg::S_EMIT;
                end
                else if (x_reg == head_reg[d_cls])
                begin
                    head_next[d_cls] = d_nxt;
                end
                else if (x_reg == tail_reg[d_cls])
                begin
                    tail_next[d_cls] = d_prv;
                end
                else
                begin
                    n_next     = d_nxt;
                    p_next     = d_prv;
                    ln_raddr   = d_prv;
                    state_next = trqa_pkg::S_RMP;
                end
            end
            trqa_pkg::S_RMP:
            begin
                ln_we      = 1'b1;
                ln_waddr   = p_reg;
                ln_wdata   = {d_cls, n_reg, d_prv};
                ln_raddr   = n_reg;
                state_next = trqa_pkg::S_RMN;
            end
            trqa_pkg::S_RMN:
            begin
                ln_we      = 1'b1;
                ln_waddr   = n_reg;
                ln_wdata   = {d_cls, d_nxt, p_reg};
                state_next = trqa_pkg::S_EMIT;
            end
            trqa_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_sv_next     = sv_reg;
                    out_sid_next    = 8'(sid_reg);
                    out_act_next    = act_reg;
                    out_pend_next   = 7'(pend_sum);
                    state_next      = trqa_pkg::S_READY;
                end
            end
            default:
            begin
                state_next = trqa_pkg::S_READY;
            end
        endcase
    end

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pend_sum) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_valid |-> status == trqa_pkg::RES_OK)
        else $error("start reported with non-ok status");

    a_queued_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == trqa_pkg::RES_QUEUED |-> pending_total != 7'd0)
        else $error("queued item but queue empty");

endmodule

// ----- dv/two_class_request_admission_queue_tb.sv -----
// Testbench for the two-class request admission queue: directed tables, a full-queue
// fill, then random request traffic checked against an in-bench admission predictor.
// Depends on trqa_pkg and the two_class_request_admission_queue RTL.
module two_class_request_admission_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDS   = 256;
    localparam int DEPTH = 64;

    typedef struct packed {
        trqa_pkg::res_t st;
        logic           sv;
        logic [7:0]     sid;
        logic [8:0]     act;
        logic [6:0]     pend;
    } outcome_t;

    typedef struct {
        trqa_pkg::cmd_t cmd;
        logic [7:0]     id;
        logic           low;
        logic           typed;
        outcome_t       want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = '0;
    logic [7:0]  request_id = '0;
    logic        low_priority = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        start_valid;
    logic [7:0]  start_id;
    logic [8:0]  active_total;
    logic [6:0]  pending_total;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    trqa_pkg::id_state_t id_state [IDS];
    logic [7:0]  wait_ids [$];
    logic        wait_low [$];
    int unsigned regular_count;
    int unsigned running;
    logic [8:0]  limit;

    outcome_t    awaited [$];
    int          errors;
    int          results_seen;
    int          sent;
    int          stall_pct;
    row_t        rows [$];

    two_class_request_admission_queue u_dut (.*);

    always #2 clk = ~clk;

    function automatic outcome_t admit(trqa_pkg::cmd_t cmd, logic [7:0] id, logic low);
        outcome_t    r;
        int unsigned pos;
        r = '{st: trqa_pkg::RES_NOT_FOUND, sv: 1'b0, sid: 8'd0, act: 9'd0, pend: 7'd0};
        unique case (cmd)
            trqa_pkg::CMD_SUBMIT:
            begin
                if (id_state[id] != trqa_pkg::ID_IDLE)
                begin
                    r.st = trqa_pkg::RES_IN_FLIGHT;
                end
                else if (running < limit)
                begin
                    id_state[id] = trqa_pkg::ID_ACTIVE;
                    running++;
                    r.st  = trqa_pkg::RES_OK;
                    r.sv  = 1'b1;
                    r.sid = id;
                end
                else if (wait_ids.size() >= DEPTH)
                begin
                    r.st = trqa_pkg::RES_FULL;
                end
                else
                begin
                    pos = low ? wait_ids.size() : regular_count;
                    wait_ids.insert(pos, id);
                    wait_low.insert(pos, low);
                    if (!low)
                    begin
                        regular_count++;
                    end
                    id_state[id] = trqa_pkg::ID_PENDING;
                    r.st = trqa_pkg::RES_QUEUED;
                end
            end
            trqa_pkg::CMD_COMPLETE,
            trqa_pkg::CMD_CANCEL:
            begin
                if (id_state[id] == trqa_pkg::ID_ACTIVE)
                begin
                    id_state[id] = trqa_pkg::ID_IDLE;
                    if (running > 0)
                    begin
                        running--;
                    end
                    if (wait_ids.size() > 0)
                    begin
                        r.sv  = 1'b1;
                        r.sid = wait_ids[0];
                        id_state[wait_ids[0]] = trqa_pkg::ID_ACTIVE;
                        if (regular_count > 0)
                        begin
                            regular_count--;
                        end
                        wait_ids.delete(0);
                        wait_low.delete(0);
                        running++;
                    end
                    r.st = trqa_pkg::RES_OK;
                end
                else if (cmd == trqa_pkg::CMD_CANCEL && id_state[id] == trqa_pkg::ID_PENDING)
                begin
                    foreach (wait_ids[k])
                    begin
                        if (wait_ids[k] == id)
                        begin
                            if (k < regular_count)
                            begin
                                regular_count--;
                            end
                            wait_ids.delete(k);
                            wait_low.delete(k);
                            break;
                        end
                    end
                    id_state[id] = trqa_pkg::ID_IDLE;
                    r.st = trqa_pkg::RES_OK;
                end
            end
            default:
            begin
            end
        endcase
        r.act  = running[8:0];
        r.pend = 7'(wait_ids.size());
        return r;
    endfunction

    task automatic send(trqa_pkg::cmd_t cmd, logic [7:0] id, logic low, logic typed,
                        outcome_t want);
        outcome_t r;
        while ($urandom_range(99) < stall_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        request_id   <= id;
        low_priority <= low;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        r = admit(cmd, id, low);
        sent++;
        if (typed && r != want)
        begin
            $error("table row disagrees with predictor: %h vs %h", want, r);
            errors++;
        end
        awaited.push_back(r);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (awaited.size() > 0 && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic set_limit(logic [8:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= {23'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit = v;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (awaited.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = awaited[0];
                awaited.delete(0);
                if (status != e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    errors++;
                end
                if (start_valid != e.sv)
                begin
                    $error("start_valid exp %0d got %0d", e.sv, start_valid);
                    errors++;
                end
                if (start_id != e.sid)
                begin
                    $error("start_id exp %0d got %0d", e.sid, start_id);
                    errors++;
                end
                if (active_total != e.act)
                begin
                    $error("active_total exp %0d got %0d", e.act, active_total);
                    errors++;
                end
                if (pending_total != e.pend)
                begin
                    $error("pending_total exp %0d got %0d", e.pend, pending_total);
                    errors++;
                end
            end
        end
    end

    function automatic row_t mk(trqa_pkg::cmd_t c, logic [7:0] id, logic low, logic t,
                                trqa_pkg::res_t s, logic sv, logic [7:0] sid,
                                logic [8:0] a, logic [6:0] p);
        row_t w;
        w.cmd   = c;
        w.id    = id;
        w.low   = low;
        w.typed = t;
        w.want  = '{st: s, sv: sv, sid: sid, act: a, pend: p};
        return w;
    endfunction

    initial
    begin
        int             n;
        int             pick;
        logic [7:0]     id;
        trqa_pkg::cmd_t c;
        errors = 0;
        results_seen = 0;
        sent = 0;
        stall_pct = 0;
        limit = trqa_pkg::MAX_ACTIVE_RESET;
        regular_count = 0;
        running = 0;
        foreach (id_state[i])
        begin
            id_state[i] = trqa_pkg::ID_IDLE;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(mk(trqa_pkg::CMD_COMPLETE, 8'd0, 1'b0, 1'b1,
                          trqa_pkg::RES_NOT_FOUND, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_CANCEL, 8'd255, 1'b1, 1'b1,
                          trqa_pkg::RES_NOT_FOUND, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_UNUSED, 8'd7, 1'b1, 1'b1,
                          trqa_pkg::RES_NOT_FOUND, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd255, 1'b0, 1'b1,
                          trqa_pkg::RES_OK, 1'b1, 8'd255, 9'd1, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd255, 1'b1, 1'b1,
                          trqa_pkg::RES_IN_FLIGHT, 1'b0, 8'd0, 9'd1, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd0, 1'b1, 1'b1,
                          trqa_pkg::RES_OK, 1'b1, 8'd0, 9'd2, 7'd0));
        foreach (rows[i])
        begin
            send(rows[i].cmd, rows[i].id, rows[i].low, rows[i].typed, rows[i].want);
        end
        rows.delete();
        drain();

        set_limit(9'd2);
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd10, 1'b1, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd11, 1'b0, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd12, 1'b1, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd13, 1'b0, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_SUBMIT, 8'd10, 1'b0, 1'b1,
                          trqa_pkg::RES_IN_FLIGHT, 1'b0, 8'd0, 9'd2, 7'd4));
        rows.push_back(mk(trqa_pkg::CMD_COMPLETE, 8'd10, 1'b0, 1'b1,
                          trqa_pkg::RES_NOT_FOUND, 1'b0, 8'd0, 9'd2, 7'd4));
        rows.push_back(mk(trqa_pkg::CMD_CANCEL, 8'd13, 1'b0, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_CANCEL, 8'd0, 1'b0, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_COMPLETE, 8'd255, 1'b0, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        rows.push_back(mk(trqa_pkg::CMD_CANCEL, 8'd12, 1'b0, 1'b0,
                          trqa_pkg::RES_OK, 1'b0, 8'd0, 9'd0, 7'd0));
        foreach (rows[i])
        begin
            send(rows[i].cmd, rows[i].id, rows[i].low, rows[i].typed, rows[i].want);
        end
        rows.delete();
        drain();

        set_limit(9'd0);
        for (int i = 0; i < 66; i++)
        begin
            send(trqa_pkg::CMD_SUBMIT, 8'(100 + i), i[0], 1'b0, '0);
        end
        drain();
        set_limit(9'd256);
        for (int i = 0; i < 8; i++)
        begin
            send(trqa_pkg::CMD_COMPLETE, 8'd0, 1'b0, 1'b0, '0);
        end
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            unique case (ph)
                0: set_limit(9'd0);
                1: set_limit(9'd1);
                2: set_limit(9'd256);
                3: set_limit(9'd4);
                4: set_limit(9'd20);
                default: set_limit(9'd8);
            endcase
            stall_pct = (ph == 2) ? 0 : 23;
            n = (ph == 2) ? 100 : 200;
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(99);
                id = (pick < 90) ? 8'($urandom_range(31)) : 8'($urandom);
                if (pick < 45)
                begin
                    c = trqa_pkg::CMD_SUBMIT;
                end
                else if (pick < 72)
                begin
                    c = trqa_pkg::CMD_COMPLETE;
                end
                else if (pick < 97)
                begin
                    c = trqa_pkg::CMD_CANCEL;
                end
                else
                begin
                    c = trqa_pkg::CMD_UNUSED;
                end
                if (c == trqa_pkg::CMD_COMPLETE && running > 0 && $urandom_range(1))
                begin
                    foreach (id_state[k])
                    begin
                        if (id_state[k] == trqa_pkg::ID_ACTIVE)
                        begin
                            id = 8'(k);
                            break;
                        end
                    end
                end
                send(c, id, 1'($urandom), 1'b0, '0);
            end
            drain();
        end

        stall_pct = 0;
        drain();
        $display("Drove %0d request items (submit, complete, cancel, unused) under six limits,",
                 sent);
        $display("with a full queue and random stalls; %0d results checked.", results_seen);
        if (errors == 0 && awaited.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/trqa_pkg.sv
src/trqa_ram.sv
src/two_class_request_admission_queue.sv
dv/two_class_request_admission_queue_tb.sv
